### rtl/bppr_pkg.sv
// Shared types and constants of the bicycle power page rotator.
`default_nettype none
package bppr_pkg;

  localparam int unsigned NumPayBytes = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;

  localparam logic [7:0] PagePower   = 8'h10;
  localparam logic [7:0] PageManuf   = 8'h50;
  localparam logic [7:0] PageProduct = 8'h51;
  localparam logic [7:0] ManufSlot   = 8'd65;
  localparam logic [7:0] FillByte    = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    RegStaleTimeout = 3'd0,
    RegHwRevision   = 3'd1,
    RegManufId      = 3'd2,
    RegModelNumber  = 3'd3,
    RegSwRevision   = 3'd4,
    RegSerial       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] stale_timeout_ms;
    logic [7:0]  hw_revision;
    logic [15:0] manufacturer_id;
    logic [15:0] model_number;
    logic [7:0]  sw_revision_main;
    logic [31:0] device_serial;
  } cfg_t;

  typedef struct packed {
    logic               data_valid;
    logic [31:0]        last_update_ms;
    logic [31:0]        now_ms;
    logic signed [15:0] power_sample;
    logic [7:0]         cadence_in;
  } item_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic [7:0]  events;
    logic [15:0] total;
  } ctr_t;

  typedef logic [NumPayBytes-1:0][7:0] payload_t;

endpackage
`default_nettype wire

### rtl/bike_power_page_rotator_core.sv
// Top level of the bicycle power page rotator: handshakes, registers, state.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | in_valid_i / in_stall_o   | data_valid, last/now ms, power, cadence
//  result   | out_valid_o / out_stall_i | pay_byte0..pay_byte7
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One slot per cycle sustained while the result side does not stall; an input transaction
// passes through the input register, then formatting logic into the result register.
// Reset clears the slot, event and power counters and loads register defaults.
// A stalled result holds; the input register still takes one more transaction
// behind it, after which in_stall_o rises.
`default_nettype none
module bike_power_page_rotator_core #(
  parameter int unsigned ROTATION_PERIOD = 130
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              data_valid_i,
  input  wire logic [31:0]                       last_update_ms_i,
  input  wire logic [31:0]                       now_ms_i,
  input  wire logic signed [15:0]                power_sample_i,
  input  wire logic [7:0]                        cadence_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [7:0]                             pay_byte0_o,
  output logic [7:0]                             pay_byte1_o,
  output logic [7:0]                             pay_byte2_o,
  output logic [7:0]                             pay_byte3_o,
  output logic [7:0]                             pay_byte4_o,
  output logic [7:0]                             pay_byte5_o,
  output logic [7:0]                             pay_byte6_o,
  output logic [7:0]                             pay_byte7_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bppr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [bppr_pkg::CfgDataW-1:0]     cfg_data_i
);
  import bppr_pkg::*;

  localparam logic [7:0] LastSlot = 8'(ROTATION_PERIOD);

  cfg_t     cfg_q;
  ctr_t     ctr_q, ctr_d;
  item_t    item_q;
  logic     item_valid_q;
  payload_t pay_q, pay_d;
  logic     out_valid_q;
  logic     advance;
  logic     in_accept;

  assign cfg_ready_o = 1'b1;

  // Move the input register into the result register when the result slot frees
  assign advance    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stale_timeout_ms <= 32'd2000;
      cfg_q.hw_revision      <= 8'd1;
      cfg_q.manufacturer_id  <= 16'd255;
      cfg_q.model_number     <= 16'd1;
      cfg_q.sw_revision_main <= 8'd1;
      cfg_q.device_serial    <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegStaleTimeout: cfg_q.stale_timeout_ms <= cfg_data_i;
        RegHwRevision:   cfg_q.hw_revision      <= cfg_data_i[7:0];
        RegManufId:      cfg_q.manufacturer_id  <= cfg_data_i[15:0];
        RegModelNumber:  cfg_q.model_number     <= cfg_data_i[15:0];
        RegSwRevision:   cfg_q.sw_revision_main <= cfg_data_i[7:0];
        RegSerial:       cfg_q.device_serial    <= cfg_data_i;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  bppr_page_fmt #(
    .ROTATION_PERIOD(ROTATION_PERIOD)
  ) u_fmt (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .ctr_i  (ctr_q),
    .ctr_o  (ctr_d),
    .pay_o  (pay_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      ctr_q        <= '0;
    end else begin
      if (in_accept) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        ctr_q       <= ctr_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.data_valid     <= data_valid_i;
      item_q.last_update_ms <= last_update_ms_i;
      item_q.now_ms         <= now_ms_i;
      item_q.power_sample   <= power_sample_i;
      item_q.cadence_in     <= cadence_in_i;
    end
    if (advance) begin
      pay_q <= pay_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pay_byte0_o = pay_q[0];
  assign pay_byte1_o = pay_q[1];
  assign pay_byte2_o = pay_q[2];
  assign pay_byte3_o = pay_q[3];
  assign pay_byte4_o = pay_q[4];
  assign pay_byte5_o = pay_q[5];
  assign pay_byte6_o = pay_q[6];
  assign pay_byte7_o = pay_q[7];

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctr_q.slot <= LastSlot)
    else $error("slot counter beyond rotation period");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_power_page_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && pay_d[0] == PagePower) |=> (ctr_q.events == $past(ctr_q.events) + 8'd1))
    else $error("power page did not advance event count");

  a_common_page_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && pay_d[0] != PagePower) |=>
      (ctr_q.events == $past(ctr_q.events) && ctr_q.total == $past(ctr_q.total)))
    else $error("common page changed power counters");

endmodule
`default_nettype wire

### rtl/bppr_page_fmt.sv
// Page selection, staleness check and payload formatting for one transmit slot.
`default_nettype none
module bppr_page_fmt #(
  parameter int unsigned ROTATION_PERIOD = 130
) (
  input  bppr_pkg::item_t    item_i,
  input  bppr_pkg::cfg_t     cfg_i,
  input  bppr_pkg::ctr_t     ctr_i,
  output bppr_pkg::ctr_t     ctr_o,
  output bppr_pkg::payload_t pay_o
);
  import bppr_pkg::*;

  localparam logic [7:0] LastSlot = 8'(ROTATION_PERIOD);

  logic [7:0]  slot_next;
  logic [31:0] age;
  logic        stale;
  logic [15:0] pw;
  logic [7:0]  cad;
  logic [7:0]  events_next;
  logic [15:0] total_next;

  // Restart at slot 1 once the period is done
  assign slot_next   = (ctr_i.slot >= LastSlot) ? 8'd1 : ctr_i.slot + 8'd1;
  assign age         = item_i.now_ms - item_i.last_update_ms;
  assign stale       = !item_i.data_valid || (age > cfg_i.stale_timeout_ms);
  assign pw          = (stale || item_i.power_sample[15]) ? 16'd0
                                                          : item_i.power_sample;
  assign cad         = stale ? FillByte : item_i.cadence_in;
  assign events_next = ctr_i.events + 8'd1;
  assign total_next  = ctr_i.total + pw;

  always_comb begin
    ctr_o      = ctr_i;
    ctr_o.slot = slot_next;
    pay_o[1]   = FillByte;
    pay_o[2]   = FillByte;
    if (slot_next == ManufSlot) begin
      pay_o[0] = PageManuf;
      pay_o[3] = cfg_i.hw_revision;
      pay_o[4] = cfg_i.manufacturer_id[7:0];
      pay_o[5] = cfg_i.manufacturer_id[15:8];
      pay_o[6] = cfg_i.model_number[7:0];
      pay_o[7] = cfg_i.model_number[15:8];
    end else if (slot_next == LastSlot) begin
      pay_o[0] = PageProduct;
      pay_o[3] = cfg_i.sw_revision_main;
      pay_o[4] = cfg_i.device_serial[7:0];
      pay_o[5] = cfg_i.device_serial[15:8];
      pay_o[6] = cfg_i.device_serial[23:16];
      pay_o[7] = cfg_i.device_serial[31:24];
    end else begin
      // Power page: advance event count and accumulated power
      ctr_o.events = events_next;
      ctr_o.total  = total_next;
      pay_o[0] = PagePower;
      pay_o[1] = events_next;
      pay_o[3] = cad;
      pay_o[4] = total_next[7:0];
      pay_o[5] = total_next[15:8];
      pay_o[6] = pw[7:0];
      pay_o[7] = pw[15:8];
    end
  end

endmodule
`default_nettype wire

### verif/tb_bike_power_page_rotator_core.sv
// Self-checking testbench of the bicycle power page rotator core.
`timescale 1ns / 100ps
module tb_bike_power_page_rotator_core;
  import bppr_pkg::*;

  localparam int unsigned RotPeriod   = 130;
  localparam int unsigned NDir        = 16;
  localparam int unsigned NPhase      = 6;
  localparam int unsigned PerPhase    = 115;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned CycLimit    = 300000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned HoldAt      = 300;

  // indexes past the last register; writes there must be dropped
  localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                data_valid_i = 1'b0;
  logic [31:0]         last_update_ms_i = '0;
  logic [31:0]         now_ms_i = '0;
  logic signed [15:0]  power_sample_i = '0;
  logic [7:0]          cadence_in_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          pay_byte0_o, pay_byte1_o, pay_byte2_o, pay_byte3_o;
  logic [7:0]          pay_byte4_o, pay_byte5_o, pay_byte6_o, pay_byte7_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  bike_power_page_rotator_core #(
    .ROTATION_PERIOD(RotPeriod)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_valid_i    (data_valid_i),
    .last_update_ms_i(last_update_ms_i),
    .now_ms_i        (now_ms_i),
    .power_sample_i  (power_sample_i),
    .cadence_in_i    (cadence_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pay_byte0_o     (pay_byte0_o),
    .pay_byte1_o     (pay_byte1_o),
    .pay_byte2_o     (pay_byte2_o),
    .pay_byte3_o     (pay_byte3_o),
    .pay_byte4_o     (pay_byte4_o),
    .pay_byte5_o     (pay_byte5_o),
    .pay_byte6_o     (pay_byte6_o),
    .pay_byte7_o     (pay_byte7_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #6 clk = ~clk;

  // shadow of the block's registers and counters
  cfg_t        cfg_sh;
  logic [7:0]  slot_no = '0;
  logic [7:0]  event_no = '0;
  logic [15:0] power_acc = '0;

  payload_t    pending_pages[$];
  int unsigned n_sent = 0;
  int unsigned errs = 0;
  int unsigned n_power = 0, n_manuf = 0, n_product = 0;
  int unsigned n_writes = 0, n_settings = 0;
  int unsigned cyc = 0;
  bit          calm = 1'b0;
  logic        park = 1'b0;

  typedef struct {
    item_t    it;
    bit       typed;
    payload_t pay;
  } dir_row_t;

  // pay is bytes 7..0, left to right; reset register values assumed
  dir_row_t dir_tab [NDir] = '{
    '{'{1'b0, 32'd0, 32'd0, 16'h0000, 8'h00}, 1'b1, 64'h00_00_00_00_FF_FF_01_10},
    '{'{1'b1, 32'd0, 32'd0, 16'h7FFF, 8'h00}, 1'b1, 64'h7F_FF_7F_FF_00_FF_02_10},
    '{'{1'b1, 32'd0, 32'd0, 16'h8000, 8'hAA}, 1'b1, 64'h00_00_7F_FF_AA_FF_03_10},
    '{'{1'b1, 32'd5, 32'd5, 16'h7FFF, 8'h55}, 1'b1, 64'h7F_FF_FF_FE_55_FF_04_10},
    '{'{1'b1, 32'd100, 32'd600, 16'h0002, 8'hC3}, 1'b1, 64'h00_02_00_00_C3_FF_05_10},
    '{'{1'b1, 32'd0, 32'd2000, 16'h0001, 8'h80}, 1'b1, 64'h00_01_00_01_80_FF_06_10},
    '{'{1'b1, 32'd0, 32'd2001, 16'h0001, 8'h80}, 1'b1, 64'h00_00_00_01_FF_FF_07_10},
    '{'{1'b1, 32'hFFFF_FFFF, 32'd0, 16'h1234, 8'h3C}, 1'b1,
      64'h12_34_12_35_3C_FF_08_10},
    '{'{1'b1, 32'd1, 32'd0, 16'h1234, 8'h3C}, 1'b1, 64'h00_00_12_35_FF_FF_09_10},
    '{'{1'b1, 32'd7, 32'd7, 16'hFFFF, 8'h01}, 1'b1, 64'h00_00_12_35_01_FF_0A_10},
    '{'{1'b0, 32'd7, 32'd7, 16'h7FFF, 8'h42}, 1'b1, 64'h00_00_12_35_FF_FF_0B_10},
    '{'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 8'hFF}, 1'b1,
      64'h7F_FF_92_34_FF_FF_0C_10},
    '{'{1'b1, 32'h8000_0000, 32'h8000_07D0, 16'h4000, 8'h7F}, 1'b0, 64'h0},
    '{'{1'b1, 32'hFFFF_F830, 32'h0000_0000, 16'h0001, 8'hFE}, 1'b0, 64'h0},
    '{'{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8001, 8'h00}, 1'b0, 64'h0},
    '{'{1'b1, 32'h0000_0000, 32'h0000_0000, 16'h0000, 8'hFF}, 1'b0, 64'h0}
  };

  // Advance the shadow counters by one slot and build its page.
  function automatic payload_t next_page(item_t it);
    payload_t    pg;
    logic [31:0] age;
    logic [15:0] pw;
    logic [7:0]  cad;
    logic        stale;
    if (slot_no >= RotPeriod) slot_no = '0;
    slot_no = slot_no + 8'd1;
    pg = '0;
    pg[1] = FillByte;
    pg[2] = FillByte;
    if (slot_no == ManufSlot) begin
      pg[0] = PageManuf;
      pg[3] = cfg_sh.hw_revision;
      pg[4] = cfg_sh.manufacturer_id[7:0];
      pg[5] = cfg_sh.manufacturer_id[15:8];
      pg[6] = cfg_sh.model_number[7:0];
      pg[7] = cfg_sh.model_number[15:8];
    end else if (slot_no == RotPeriod[7:0]) begin
      pg[0] = PageProduct;
      pg[3] = cfg_sh.sw_revision_main;
      pg[4] = cfg_sh.device_serial[7:0];
      pg[5] = cfg_sh.device_serial[15:8];
      pg[6] = cfg_sh.device_serial[23:16];
      pg[7] = cfg_sh.device_serial[31:24];
    end else begin
      age   = it.now_ms - it.last_update_ms;
      stale = !it.data_valid || (age > cfg_sh.stale_timeout_ms);
      // clamp negative power to zero
      pw    = (stale || it.power_sample[15]) ? 16'h0000 : it.power_sample;
      cad   = stale ? FillByte : it.cadence_in;
      event_no  = event_no + 8'd1;
      power_acc = power_acc + pw;
      pg[0] = PagePower;
      pg[1] = event_no;
      pg[3] = cad;
      pg[4] = power_acc[7:0];
      pg[5] = power_acc[15:8];
      pg[6] = pw[7:0];
      pg[7] = pw[15:8];
    end
    return pg;
  endfunction

  function automatic int unsigned idle_len(int unsigned pct_busy);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r >= pct_busy) return 0;
    if (r >= pct_busy / 5) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic item_t rand_slot();
    item_t       it;
    logic [31:0] age;
    it.data_valid = ($urandom_range(0, 99) < 85);
    it.now_ms     = $urandom;
    case ($urandom_range(0, 3))
      0:       age = $urandom_range(0, 10);
      1:       age = cfg_sh.stale_timeout_ms + $urandom_range(0, 4) - 2;
      2:       age = $urandom_range(0, 5000);
      default: age = $urandom;
    endcase
    it.last_update_ms = it.now_ms - age;
    case ($urandom_range(0, 4))
      0: it.power_sample = 16'($urandom);
      1: it.power_sample = 16'($urandom_range(0, 1500));
      2: it.power_sample = 16'h8000 | 16'($urandom);
      3: begin
        case ($urandom_range(0, 3))
          0:       it.power_sample = 16'h7FFF;
          1:       it.power_sample = 16'h8000;
          2:       it.power_sample = 16'h0000;
          default: it.power_sample = 16'hFFFF;
        endcase
      end
      default: it.power_sample = 16'($urandom_range(0, 32767));
    endcase
    it.cadence_in = 8'($urandom);
    return it;
  endfunction

  // Offer one slot and hold it until the transaction completes.
  task automatic offer_slot(input item_t it, input bit typed, input payload_t want);
    payload_t    pg;
    int unsigned gap;
    in_valid_i       <= 1'b1;
    data_valid_i     <= it.data_valid;
    last_update_ms_i <= it.last_update_ms;
    now_ms_i         <= it.now_ms;
    power_sample_i   <= it.power_sample;
    cadence_in_i     <= it.cadence_in;
    do @(posedge clk); while (in_stall_o);
    pg = next_page(it);
    pending_pages.push_back(typed ? want : pg);
    n_sent++;
    gap = idle_len(40);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    n_writes++;
  endtask

  // Write every register; junk in the upper bits of narrow ones must be dropped.
  task automatic load_regs(input cfg_t nv);
    put_reg(RegStaleTimeout, nv.stale_timeout_ms);
    put_reg(RegHwRevision, {24'($urandom), nv.hw_revision});
    put_reg(RegManufId, {16'($urandom), nv.manufacturer_id});
    put_reg(RegModelNumber, {16'($urandom), nv.model_number});
    put_reg(RegSwRevision, {24'($urandom), nv.sw_revision_main});
    put_reg(RegSerial, nv.device_serial);
    put_reg(RegSpareA, $urandom);
    put_reg(RegSpareB, $urandom);
    cfg_valid_i <= 1'b0;
    cfg_sh = nv;
    n_settings++;
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (pending_pages.size() != 0) @(posedge clk);
  endtask

  task automatic check_page();
    payload_t got, want;
    got = {pay_byte7_o, pay_byte6_o, pay_byte5_o, pay_byte4_o,
           pay_byte3_o, pay_byte2_o, pay_byte1_o, pay_byte0_o};
    if (pending_pages.size() == 0) begin
      $display("%0t: unexpected page, expected none, got %h", $time, got);
      errs++;
    end else begin
      want = pending_pages.pop_front();
      for (int i = 0; i < NumPayBytes; i++) begin
        if (got[i] !== want[i]) begin
          $display("%0t: pay_byte%0d expected %02h got %02h", $time, i, want[i], got[i]);
          errs++;
        end
      end
      if (want[0] == PageManuf) n_manuf++;
      else if (want[0] == PageProduct) n_product++;
      else n_power++;
    end
  endtask

  // result side: take transactions and stall at random
  initial begin : drain_pages
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_ni && out_valid_o && !out_stall_i) check_page();
      if (hold != 0) hold--;
      else hold = idle_len(25);
      out_stall_i <= park || (hold != 0);
    end
  end

  // Hold off the result side long enough to back up the input.
  initial begin : long_hold
    wait (n_sent >= HoldAt);
    @(posedge clk);
    park <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    park <= 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CycLimit) begin
      $display("%0t: run did not complete, %0d pages still pending", $time,
               pending_pages.size());
      $display("tb_bike_power_page_rotator_core NOT OK");
      $finish;
    end
  end

  initial begin : main_seq
    cfg_t nv;
    cfg_sh = '{stale_timeout_ms: 32'd2000, hw_revision: 8'd1, manufacturer_id: 16'd255,
               model_number: 16'd1, sw_revision_main: 8'd1, device_serial: 32'd0};
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < NDir; k++) offer_slot(dir_tab[k].it, dir_tab[k].typed, dir_tab[k].pay);
    finish_phase();

    for (int ph = 0; ph < NPhase; ph++) begin
      case (ph)
        0: nv = '1;
        1: nv = '0;
        default: begin
          case ($urandom_range(0, 2))
            0:       nv.stale_timeout_ms = $urandom_range(0, 50);
            1:       nv.stale_timeout_ms = $urandom_range(1000, 5000);
            default: nv.stale_timeout_ms = $urandom;
          endcase
          nv.hw_revision      = 8'($urandom);
          nv.manufacturer_id  = 16'($urandom);
          nv.model_number     = 16'($urandom);
          nv.sw_revision_main = 8'($urandom);
          nv.device_serial    = $urandom;
        end
      endcase
      calm = (ph == 2);
      load_regs(nv);
      repeat (PerPhase) offer_slot(rand_slot(), 1'b0, '0);
      finish_phase();
    end

    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d slots: %0d power, %0d manufacturer, %0d product pages.",
             n_sent, n_power, n_manuf, n_product);
    $display("Register transactions: %0d over %0d settings, %0d mismatches.",
             n_writes, n_settings, errs);
    if (errs == 0) begin
      $display("tb_bike_power_page_rotator_core OK");
    end else begin
      $display("tb_bike_power_page_rotator_core NOT OK");
    end
    $finish;
  end

endmodule
